// ===== sv/kped_pkg.sv =====
// ----------------------------------------------------------------------------
// kped_pkg: shared types and constants of the key press event detector
// Holds the item layouts, the phase type, event bits and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package kped_pkg;

	// Default number of key lines.
	localparam int unsigned NUM_KEYS_DEF = 8;

	// Fixed field widths.
	localparam int unsigned KEY_W   = 8;
	localparam int unsigned EV_W    = 4;
	localparam int unsigned TICKS_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Item kinds.
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Event flag bits.
	localparam logic [EV_W-1:0] EV_PRESS   = 4'b0001;
	localparam logic [EV_W-1:0] EV_LONG    = 4'b0010;
	localparam logic [EV_W-1:0] EV_REPEAT  = 4'b0100;
	localparam logic [EV_W-1:0] EV_RELEASE = 4'b1000;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS = 2'd2;

	// Register reset values.
	localparam logic [TICKS_W-1:0] PRESS_TICKS_RST  = 16'd3;
	localparam logic [TICKS_W-1:0] LONG_TICKS_RST   = 16'd100;
	localparam logic [TICKS_W-1:0] REPEAT_TICKS_RST = 16'd20;

	localparam logic [TICKS_W-1:0] TIMER_MAX = '1;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SETTLE = 2'd1,
		PH_DOWN   = 2'd2,
		PH_HELD   = 2'd3
	} phase_t;

	typedef struct packed {
		logic              func;
		logic [KEY_W-1:0]  key_sample;
		logic [KEY_W-1:0]  query_key;
		logic [EV_W-1:0]   query_events;
	} kped_item_t;

	typedef struct packed {
		logic              hit;
		logic [KEY_W-1:0]  latched_key;
		logic [EV_W-1:0]   latched_events;
	} kped_result_t;

	typedef struct packed {
		logic [TICKS_W-1:0] press_ticks;
		logic [TICKS_W-1:0] long_ticks;
		logic [TICKS_W-1:0] repeat_ticks;
	} kped_cfg_t;

endpackage

`default_nettype wire

// ===== sv/kped_if.sv =====
// ----------------------------------------------------------------------------
// kped_if: item channels of the key press event detector
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface kped_in_if
	import kped_pkg::*;
	();
	logic       valid;
	logic       ready;
	kped_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface kped_out_if
	import kped_pkg::*;
	();
	logic         valid;
	logic         ready;
	kped_result_t result;

	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== sv/kped_cfg.sv =====
// ----------------------------------------------------------------------------
// kped_cfg: threshold registers
// Holds press, long and repeat tick thresholds written over the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module kped_cfg
	import kped_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TICKS_W-1:0]   cfg_data,
	output kped_cfg_t                 cfg
);

	kped_cfg_t cfg_q;

	// Register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_ticks  <= PRESS_TICKS_RST;
			cfg_q.long_ticks   <= LONG_TICKS_RST;
			cfg_q.repeat_ticks <= REPEAT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRESS_TICKS:  cfg_q.press_ticks  <= cfg_data;
				CFG_LONG_TICKS:   cfg_q.long_ticks   <= cfg_data;
				CFG_REPEAT_TICKS: cfg_q.repeat_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/kped_fsm.sv =====
// ----------------------------------------------------------------------------
// kped_fsm: press timing machine and sticky event latch
// Holds phase, last sample, hold timer and latched events; updates on step.
// ----------------------------------------------------------------------------
`default_nettype none

module kped_fsm
	import kped_pkg::*;
#(
	parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire kped_item_t item,
	input  wire kped_cfg_t  cfg,
	output kped_result_t    result
);

	// Stored key width: key lines beyond the byte are never seen
	localparam int unsigned KeyW = (NUM_KEYS >= KEY_W) ? KEY_W : NUM_KEYS;

	phase_t               phase_q, phase_n;
	logic [KeyW-1:0]      prev_q, ekey_q, ekey_n;
	logic [TICKS_W-1:0]   timer_q, timer_n, timer_inc;
	logic [EV_W-1:0]      flags_q, flags_n;
	logic [KeyW-1:0]      cur;
	logic                 is_tick, same, cur_zero, hit;
	logic [EV_W-1:0]      latch_ev;

	assign is_tick   = (item.func == FUNC_TICK);
	assign cur       = item.key_sample[KeyW-1:0];
	assign same      = (cur == prev_q);
	assign cur_zero  = (cur == '0);
	assign timer_inc = (timer_q == TIMER_MAX) ? timer_q : timer_q + 1'b1;

	// Next phase
	always_comb begin
		phase_n = phase_q;
		if (is_tick) begin
			unique case (phase_q)
				PH_IDLE:   if (!cur_zero) phase_n = PH_SETTLE;
				PH_SETTLE: phase_n = PH_DOWN;
				PH_DOWN: begin
					if (same) begin
						if (timer_inc >= cfg.long_ticks) phase_n = PH_HELD;
					end else begin
						phase_n = PH_IDLE;
					end
				end
				PH_HELD:   if (!same && cur_zero) phase_n = PH_IDLE;
				default:   phase_n = PH_IDLE;
			endcase
		end
	end

	// Timer and event to latch on a tick
	always_comb begin
		timer_n  = timer_q;
		latch_ev = '0;
		unique case (phase_q)
			PH_IDLE:   timer_n = '0;
			PH_SETTLE: ;
			PH_DOWN: begin
				timer_n = timer_inc;
				if (same) begin
					if (timer_inc >= cfg.long_ticks) latch_ev = EV_LONG;
				end else if (cur_zero && timer_inc >= cfg.press_ticks) begin
					latch_ev = EV_PRESS;
				end
			end
			PH_HELD: begin
				if (same) begin
					if (timer_inc >= cfg.repeat_ticks) begin
						latch_ev = EV_REPEAT;
						timer_n  = '0;
					end else begin
						timer_n = timer_inc;
					end
				end else if (cur_zero) begin
					latch_ev = EV_RELEASE;
				end
			end
			default: ;
		endcase
	end

	// Sticky events; a query hit clears them
	always_comb begin
		ekey_n  = ekey_q;
		flags_n = flags_q;
		hit     = 1'b0;
		if (is_tick) begin
			if (latch_ev != '0) begin
				ekey_n  = prev_q;
				flags_n = flags_q | latch_ev;
			end
		end else if ((KEY_W'(ekey_q) == item.query_key) &&
				((flags_q & item.query_events) != '0)) begin
			flags_n = '0;
			hit     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			prev_q  <= '0;
			timer_q <= '0;
			ekey_q  <= '0;
			flags_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			ekey_q  <= ekey_n;
			flags_q <= flags_n;
			if (is_tick) begin
				prev_q  <= cur;
				timer_q <= timer_n;
			end
		end
	end

	assign result.hit            = hit;
	assign result.latched_key    = KEY_W'(ekey_n);
	assign result.latched_events = flags_n;

endmodule

`default_nettype wire

// ===== sv/key_press_event_detector.sv =====
// ----------------------------------------------------------------------------
// key_press_event_detector: debounced key events with sticky latching
// Scan ticks time key presses; queries poll and clear latched events.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items: func = 0 is a scan tick with key_sample, func = 1 a
//   query with query_key and query_events. Every item gives one result on
//   out_ch: hit, latched_key and latched_events after that item.
//   The cfg port writes press_ticks (0), long_ticks (1), repeat_ticks (2); the
//   user writes while the block is idle, unenforced; other indexes are dropped.
//   An accepted item waits in the input register while the combinational
//   state update runs; the result register loads when the result slot is free,
//   and the state registers load on that same edge. Throughput is one item per
//   cycle while out_ch does not stall, set by the combinational state update.
//   When out_ch stalls, the result register holds its item and the input
//   register holds one more; in_ch.ready drops only when both are full.
//   Reset clears the phase, timer, last sample, latched key and events, and
//   loads the threshold defaults 3, 100 and 20.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_event_detector
	import kped_pkg::*;
#(
	parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	kped_in_if.sink                   in_ch,
	kped_out_if.source                out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TICKS_W-1:0]   cfg_data
);

	kped_cfg_t    cfg;
	kped_item_t   item_s1;
	logic         valid_s1;
	logic         out_valid_q;
	kped_result_t out_q;
	kped_result_t result;
	logic         step;

	kped_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Item in the input register moves on when the result slot frees up
	assign step        = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= in_ch.item;
		end
	end

	kped_fsm #(
		.NUM_KEYS (NUM_KEYS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.result = out_q;

endmodule

`default_nettype wire
